FILE: hdl/sha1_pkg.sv
// Shared types and constants for the SHA-1 message digest engine.
package sha1_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } word_entry_t;

endpackage

FILE: hdl/sha1_front.sv
// Input queue: accepts message words and holds them for the packing engine.
module sha1_front #(
    parameter int DEPTH_LOG2 = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sha1_pkg::word_entry_t in_entry,
    output logic                 q_valid,
    input  logic                 q_pop,
    output sha1_pkg::word_entry_t q_entry
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    sha1_pkg::word_entry_t  mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0]  wr_ptr_reg;
    logic [DEPTH_LOG2-1:0]  rd_ptr_reg;
    logic [DEPTH_LOG2:0]    count_reg;
    logic                   push;
    logic                   pop;

    assign in_stall = (count_reg == (DEPTH_LOG2+1)'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_entry  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (DEPTH_LOG2+1)'(push) - (DEPTH_LOG2+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == (DEPTH_LOG2+1)'(DEPTH) |-> !push || pop)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |=> count_reg <= (DEPTH_LOG2+1)'(1))
        else $error("queue count jump");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (DEPTH_LOG2+1)'(DEPTH))
        else $error("queue count out of range");

endmodule

FILE: hdl/sha1_core.sv
// Back end: byte packing, padding, 80-round compression and digest output.
module sha1_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  sha1_pkg::word_entry_t q_entry,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           digest_word,
    output logic [2:0]            word_index,
    output logic                  digest_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTES,
        S_PAD,
        S_ROUND,
        S_EMIT
    } state_t;

    state_t        state_reg;
    logic [31:0]   buf_reg [16];
    logic [31:0]   cv_reg [5];
    logic [31:0]   a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]   w_reg [16];
    logic [6:0]    round_reg;
    logic [63:0]   bits_reg;
    logic [63:0]   len_reg;
    logic [5:0]    fill_reg;
    logic [31:0]   word_reg;
    logic [2:0]    left_reg;
    logic          last_reg;
    logic          padding_reg;
    logic [3:0]    pad_pos_reg;
    logic          pad_first_reg;
    logic [2:0]    emit_reg;

    logic [31:0]   f_val;
    logic [31:0]   k_val;
    logic [31:0]   t_val;
    logic [31:0]   w_new;
    logic [7:0]    pad_byte;
    logic [7:0]    in_byte;
    logic [2:0]    count_sat;

    assign count_sat = (q_entry.byte_count > 3'd4) ? 3'd4 : q_entry.byte_count;
    assign q_pop     = (state_reg == S_IDLE);

    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_pkg::K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_pkg::K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
    end

    always_comb
    begin
        logic [31:0] x;
        x     = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {x[30:0], x[31]};
    end

    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_byte = 8'h80;
        end
        else if (fill_reg >= 6'd56 && pad_pos_reg == 4'd2)
        begin
            pad_byte = len_reg[63 - 8*(fill_reg[2:0]) -: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
        in_byte = word_reg[31:24];
    end

    assign digest_word = cv_reg[emit_reg];
    assign word_index  = emit_reg;
    assign digest_last = (emit_reg == 3'd4);
    assign out_valid   = (state_reg == S_EMIT);

    always_ff @(posedge clk)
    begin
        logic [7:0] bv;
        bv = padding_reg ? pad_byte : in_byte;
        if (state_reg == S_BYTES || state_reg == S_PAD)
        begin
            buf_reg[fill_reg[5:2]][31 - 8*fill_reg[1:0] -: 8] <= bv;
        end
        if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
        else
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= buf_reg[i];
            end
            if (fill_reg == 6'd63 && (state_reg == S_BYTES || state_reg == S_PAD))
            begin
                w_reg[15] <= {buf_reg[15][31:8], bv};
            end
        end
        if (state_reg == S_IDLE && q_valid)
        begin
            word_reg <= q_entry.data_word;
        end
        else if (state_reg == S_BYTES)
        begin
            word_reg <= {word_reg[23:0], 8'h00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cv_reg[0]     <= sha1_pkg::IV0;
            cv_reg[1]     <= sha1_pkg::IV1;
            cv_reg[2]     <= sha1_pkg::IV2;
            cv_reg[3]     <= sha1_pkg::IV3;
            cv_reg[4]     <= sha1_pkg::IV4;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            e_reg         <= '0;
            round_reg     <= '0;
            bits_reg      <= '0;
            len_reg       <= '0;
            fill_reg      <= '0;
            left_reg      <= '0;
            last_reg      <= 1'b0;
            padding_reg   <= 1'b0;
            pad_pos_reg   <= '0;
            pad_first_reg <= 1'b0;
            emit_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        left_reg    <= count_sat;
                        last_reg    <= q_entry.last_word;
                        padding_reg <= 1'b0;
                        bits_reg    <= bits_reg + {58'd0, count_sat, 3'd0};
                        len_reg     <= bits_reg + {58'd0, count_sat, 3'd0};
                        if (count_sat != 3'd0)
                        begin
                            state_reg <= S_BYTES;
                        end
                        else if (q_entry.last_word)
                        begin
                            padding_reg   <= 1'b1;
                            pad_first_reg <= 1'b1;
                            state_reg     <= S_PAD;
                        end
                    end
                end
                S_BYTES:
                begin
                    fill_reg <= fill_reg + 6'd1;
                    left_reg <= left_reg - 3'd1;
                    if (fill_reg == 6'd63)
                    begin
                        a_reg     <= cv_reg[0];
                        b_reg     <= cv_reg[1];
                        c_reg     <= cv_reg[2];
                        d_reg     <= cv_reg[3];
                        e_reg     <= cv_reg[4];
                        round_reg <= '0;
                        state_reg <= S_ROUND;
                    end
                    else if (left_reg == 3'd1)
                    begin
                        if (last_reg)
                        begin
                            padding_reg   <= 1'b1;
                            pad_first_reg <= 1'b1;
                            state_reg     <= S_PAD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_PAD:
                begin
                    pad_first_reg <= 1'b0;
                    fill_reg      <= fill_reg + 6'd1;
                    if (fill_reg < 6'd56)
                    begin
                        pad_pos_reg <= 4'd2;
                    end
                    if (fill_reg == 6'd63)
                    begin
                        a_reg     <= cv_reg[0];
                        b_reg     <= cv_reg[1];
                        c_reg     <= cv_reg[2];
                        d_reg     <= cv_reg[3];
                        e_reg     <= cv_reg[4];
                        round_reg <= '0;
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    a_reg     <= t_val;
                    b_reg     <= a_reg;
                    c_reg     <= {b_reg[1:0], b_reg[31:2]};
                    d_reg     <= c_reg;
                    e_reg     <= d_reg;
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == 7'd79)
                    begin
                        cv_reg[0] <= cv_reg[0] + t_val;
                        cv_reg[1] <= cv_reg[1] + a_reg;
                        cv_reg[2] <= cv_reg[2] + {b_reg[1:0], b_reg[31:2]};
                        cv_reg[3] <= cv_reg[3] + c_reg;
                        cv_reg[4] <= cv_reg[4] + d_reg;
                        if (!padding_reg)
                        begin
                            if (left_reg != 3'd0)
                            begin
                                state_reg <= S_BYTES;
                            end
                            else if (last_reg)
                            begin
                                padding_reg   <= 1'b1;
                                pad_first_reg <= 1'b1;
                                pad_pos_reg   <= '0;
                                state_reg     <= S_PAD;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        else if (pad_pos_reg == 4'd2)
                        begin
                            emit_reg  <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!out_stall)
                    begin
                        if (emit_reg == 3'd4)
                        begin
                            emit_reg    <= '0;
                            cv_reg[0]   <= sha1_pkg::IV0;
                            cv_reg[1]   <= sha1_pkg::IV1;
                            cv_reg[2]   <= sha1_pkg::IV2;
                            cv_reg[3]   <= sha1_pkg::IV3;
                            cv_reg[4]   <= sha1_pkg::IV4;
                            bits_reg    <= '0;
                            fill_reg    <= '0;
                            padding_reg <= 1'b0;
                            pad_pos_reg <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            emit_reg <= emit_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> emit_reg <= 3'd4)
        else $error("digest index out of range");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND |-> round_reg <= 7'd79)
        else $error("round counter out of range");
    a_emit_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_reg == 6'd0)
        else $error("digest with partial block");

endmodule

FILE: hdl/sha1_message_digest.sv
// Top level of the streaming SHA-1 message digest engine.
//
// Input channel: data_word carries up to four message bytes, first byte in
// bits 31..24; byte_count gives how many leading bytes are valid (5..7 act
// as 4). last_word closes the message; a last word may carry zero bytes.
// A transfer completes when in_valid is high and in_stall is low.
// Output channel: on each last word five transfers follow, digest words
// 0..4 with word_index and digest_last high on the fifth.
// Words pass a two-entry queue into the packing engine, which takes a word and
// then packs its bytes one at a time, taking the next word only once back in
// idle, and runs one SHA-1 round per cycle over each full block.
// Padding adds up to 72 bytes and one or two compressions before the
// digest appears, one word per cycle while out_stall is low.
// Reset loads the initial vector and clears counters and the queue.
// While out_stall is high the current digest word holds and the engine
// waits; the queue keeps taking words until it fills.
module sha1_message_digest #(
    parameter int QUEUE_DEPTH_LOG2 = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);

    sha1_pkg::word_entry_t in_entry;
    sha1_pkg::word_entry_t q_entry;
    logic                  q_valid;
    logic                  q_pop;

    assign in_entry = '{data_word: data_word, byte_count: byte_count, last_word: last_word};

    sha1_front #(
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_entry (in_entry),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_entry  (q_entry)
    );

    sha1_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_entry     (q_entry),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .digest_last (digest_last)
    );

endmodule

FILE: dv/sha1_message_digest_tb.sv
// Testbench for the streaming SHA-1 message digest engine: directed and random messages.
`timescale 1ns / 100ps

module sha1_message_digest_tb;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } digest_entry_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    logic [31:0] hash_state [5];
    logic [31:0] block_words [16];
    logic [63:0] bit_length;
    logic [5:0]  block_fill;

    digest_entry_t expected_digests [$];
    int  error_count;
    int  cycle_count;
    bit  send_idle_on;
    bit  recv_idle_on;

    sha1_message_digest DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digest_word(digest_word),
        .word_index (word_index),
        .digest_last(digest_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] rotl(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = block_words[r];
        for (int r = 16; r < 80; r++)
            w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K3;
            end
            t = rotl(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    function automatic void append_byte(logic [7:0] value);
        block_words[block_fill[5:2]][(3 - block_fill[1:0]) * 8 +: 8] = value;
        block_fill = block_fill + 6'd1;
        if (block_fill == 6'd0)
            compress_block();
    endfunction

    function automatic void restart_message();
        hash_state[0] = sha1_pkg::IV0;
        hash_state[1] = sha1_pkg::IV1;
        hash_state[2] = sha1_pkg::IV2;
        hash_state[3] = sha1_pkg::IV3;
        hash_state[4] = sha1_pkg::IV4;
        bit_length = 64'd0;
        block_fill = 6'd0;
    endfunction

    function automatic void predict_digest(logic [31:0] word, logic [2:0] count, logic last);
        int n;
        logic [63:0] len;
        digest_entry_t entry;
        n = (count > 3'd4) ? 4 : int'(count);
        for (int i = 0; i < n; i++)
        begin
            append_byte(word[(3 - i) * 8 +: 8]);
            bit_length += 64'd8;
        end
        if (last)
        begin
            len = bit_length;
            append_byte(8'h80);
            while (block_fill != 6'd56)
                append_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_byte(len[(7 - i) * 8 +: 8]);
            for (int i = 0; i < 5; i++)
            begin
                entry.digest_word = hash_state[i];
                entry.word_index  = 3'(i);
                entry.digest_last = (i == 4);
                expected_digests.push_back(entry);
            end
            restart_message();
        end
    endfunction

    task automatic send_word(logic [31:0] word, logic [2:0] count, logic last);
        while (send_idle_on && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= word;
        byte_count <= count;
        last_word  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_digest(word, count, last);
    endtask

    task automatic send_message(int bytes, int tail_count);
        int left;
        int n;
        left = bytes;
        while (left > 4)
        begin
            send_word($urandom, 3'd4, 1'b0);
            left -= 4;
        end
        n = (tail_count >= 0) ? tail_count : left;
        send_word($urandom, 3'(n), 1'b1);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_digests.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_known_vectors();
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word(32'hFFFFFFFF, 3'd7, 1'b0);
        send_word(32'h00000000, 3'd5, 1'b0);
        send_word(32'hA5A5A5A5, 3'd6, 1'b1);
    endtask

    task automatic test_short_and_empty_words();
        send_word(32'h12345678, 3'd1, 1'b0);
        send_word(32'hDEADBEEF, 3'd0, 1'b0);
        send_word(32'hCAFEF00D, 3'd2, 1'b0);
        send_word(32'h55AA55AA, 3'd3, 1'b0);
        send_word(32'h0F0F0F0F, 3'd0, 1'b1);
    endtask

    task automatic test_padding_boundaries();
        send_message(52, 4);
        send_message(56, 4);
        send_message(60, 4);
        send_message(64, 4);
        send_message(64, 0);
    endtask

    task automatic test_random_messages();
        int sent;
        int bytes;
        bit drained;
        sent = 0;
        drained = 1'b0;
        while (sent < 140)
        begin
            if (sent > 40 && sent < 90)
                send_idle_on = 1'b0;
            else
                send_idle_on = 1'b1;
            if ($urandom_range(9) == 0)
            begin
                send_word($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                bytes = $urandom_range(3) == 0 ? $urandom_range(130) : $urandom_range(40);
                send_message(bytes, $urandom_range(4) == 0 ? $urandom_range(7) : -1);
                sent += bytes / 4 + 1;
            end
            if (!drained && sent > 100)
            begin
                wait_results_drained();
                drained = 1'b1;
            end
        end
        send_idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        digest_entry_t exp;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_digests.size() == 0)
                begin
                    $error("unexpected transfer: digest_word %h", digest_word);
                    error_count++;
                end
                else
                begin
                    exp = expected_digests.pop_front();
                    if (digest_word !== exp.digest_word)
                    begin
                        $error("digest_word expected %h actual %h", exp.digest_word, digest_word);
                        error_count++;
                    end
                    if (word_index !== exp.word_index)
                    begin
                        $error("word_index expected %0d actual %0d", exp.word_index, word_index);
                        error_count++;
                    end
                    if (digest_last !== exp.digest_last)
                    begin
                        $error("digest_last expected %0d actual %0d",
                               exp.digest_last, digest_last);
                        error_count++;
                    end
                end
            end
            out_stall <= recv_idle_on && ($urandom_range(99) < 25);
        end
    end

    initial
    begin
        recv_idle_on = 1'b1;
        forever
        begin
            repeat (3000) @(posedge clk);
            recv_idle_on = 1'b0;
            repeat (1500) @(posedge clk);
            recv_idle_on = 1'b1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_word    = 32'h0;
        byte_count   = 3'd0;
        last_word    = 1'b0;
        out_stall    = 1'b0;
        error_count  = 0;
        cycle_count  = 0;
        send_idle_on = 1'b1;
        restart_message();
        for (int i = 0; i < 16; i++)
            block_words[i] = 32'h0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_known_vectors();
        test_short_and_empty_words();
        test_padding_boundaries();
        test_random_messages();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_digests.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/sha1_pkg.sv
hdl/sha1_front.sv
hdl/sha1_core.sv
hdl/sha1_message_digest.sv
dv/sha1_message_digest_tb.sv
